[rtl/cpts_pkg.sv]
package cpts_pkg;

    // Number of task slots in the table.
    localparam int TASK_SLOTS = 64;
    localparam int IDX_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    // Operation codes carried on s_tuser.
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_YIELD   = 3'd1;
    localparam logic [2:0] OP_LOAD    = 3'd2;
    localparam logic [2:0] OP_PDIS    = 3'd3;
    localparam logic [2:0] OP_PEN     = 3'd4;

    // Packed widths of the stream payloads.
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 8;

    // One entry of the task table.
    typedef struct packed {
        logic       present;
        logic       runnable;
        logic [6:0] prio;
        logic [7:0] cnt;
        logic [3:0] pre;
    } slot_rec_t;

endpackage

[rtl/counter_priority_task_scheduler.sv]
// Counter/priority task scheduler with a table of TASK_SLOTS task slots.
//
// Input channel (s_*): each transaction carries one operation on s_tuser
// (tick, yield, load slot, preempt disable, preempt enable) and the load
// fields on s_tdata. Result channel (m_*): exactly one transaction per input
// transaction, giving the current task, a switched flag and a recharged flag.
//
// The block works on one operation at a time and holds s_tready low while it
// is busy. An unknown operation goes straight to the result; a load, a
// preempt change or a tick that does not reschedule first rewrites one table
// entry. Scheduling walks the table one slot per cycle through one compare
// unit and the table's one read port. When the counters are recharged, a
// second walk rewrites every present slot and picks the winner at the same
// time.
//
// Reset (aresetn low, synchronous) returns the block to idle, drops m_tvalid
// and marks every table entry as holding its reset value (slot 0 present,
// runnable and of priority one, all others empty); no clearing pass is needed.
// A stalled result waits in the output register; the block may accept and work
// on the next transaction but does not finish it until that result is taken.
module counter_priority_task_scheduler
    import cpts_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [5:0] slot_index, [6] slot_present, [7] slot_runnable,
    // [14:8] slot_priority, [22:15] slot_counter, [23] zero.
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [2:0] operation.
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [5:0] current_task, [6] switched, [7] recharged.
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CUR  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_RECH = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TASK_SLOTS - 1);
    localparam logic [IDX_W:0]   SCAN_END  = (IDX_W + 1)'(TASK_SLOTS);
    localparam slot_rec_t        SLOT0_RST = '{present: 1'b1, runnable: 1'b1,
                                              prio: 7'd1, cnt: 8'd0, pre: 4'd0};

    // Task table: one record per slot, one write and one registered read a cycle.
    slot_rec_t slot_mem [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] valid_reg;

    logic [2:0]       state_reg,    state_next;
    logic [2:0]       op_reg,       op_next;
    logic [IDX_W-1:0] cur_reg,      cur_next;
    logic [IDX_W-1:0] before_reg,   before_next;
    logic [IDX_W:0]   scan_reg,     scan_next;
    logic             live_reg,     live_next;
    logic             found_reg,    found_next;
    logic [7:0]       best_cnt_reg, best_cnt_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic             rch_reg,      rch_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // A load keeps the slot's preemption count, so it is held here while the
    // old entry is read back.
    slot_rec_t        load_reg,      load_next;
    logic [IDX_W-1:0] load_addr_reg, load_addr_next;
    logic             load_en_reg,   load_en_next;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] rd_addr_reg;
    slot_rec_t        rd_data_reg;
    logic             rd_vld_reg;
    slot_rec_t        eff_rec;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    slot_rec_t        wr_data;

    logic             accept;
    logic             load_in_range;
    slot_rec_t        load_rec;
    slot_rec_t        upd_rec;
    logic [8:0]       rech_sum;
    logic [7:0]       rech_cnt;
    logic [7:0]       cand_cnt;
    logic             take;
    logic             pass_end;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign load_in_range = (32'(s_tdata[5:0]) < TASK_SLOTS);
    assign load_rec = '{present: s_tdata[6], runnable: s_tdata[7],
                        prio: s_tdata[14:8], cnt: s_tdata[22:15], pre: 4'd0};

    // An entry never written since reset reads as its reset value.
    always_comb begin
        if (rd_vld_reg) begin
            eff_rec = rd_data_reg;
        end else if (rd_addr_reg == '0) begin
            eff_rec = SLOT0_RST;
        end else begin
            eff_rec = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= slot_mem[rd_addr];
        rd_vld_reg  <= valid_reg[rd_addr];
        rd_addr_reg <= rd_addr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Shared recharge and compare unit used by both table walks.
    assign rech_sum = {2'b00, eff_rec.cnt[7:1]} + {2'b00, eff_rec.prio};
    always_comb begin
        if (!eff_rec.present) begin
            rech_cnt = eff_rec.cnt;
        end else if (rech_sum[8]) begin
            rech_cnt = 8'hFF;
        end else begin
            rech_cnt = rech_sum[7:0];
        end
    end
    assign cand_cnt = (state_reg == S_RECH) ? rech_cnt : eff_rec.cnt;
    assign take     = live_reg && eff_rec.present && eff_rec.runnable &&
                      (!found_reg || (cand_cnt > best_cnt_reg));
    assign pass_end = live_reg && (rd_addr_reg == LAST_IDX);

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        cur_next       = cur_reg;
        before_next    = before_reg;
        scan_next      = scan_reg;
        found_next     = found_reg;
        best_cnt_next  = best_cnt_reg;
        best_idx_next  = best_idx_reg;
        rch_next       = rch_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        load_next      = load_reg;
        load_addr_next = load_addr_reg;
        load_en_next   = load_en_reg;
        live_next      = 1'b0;
        rd_addr        = cur_reg;
        wr_en          = 1'b0;
        wr_addr        = cur_reg;
        wr_data        = eff_rec;
        upd_rec        = eff_rec;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (take) begin
            found_next    = 1'b1;
            best_cnt_next = cand_cnt;
            best_idx_next = rd_addr_reg;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next     = s_tuser;
                    before_next = cur_reg;
                    rch_next    = 1'b0;
                    case (s_tuser)
                        OP_LOAD: begin
                            // Read the old entry so that its preemption count survives.
                            rd_addr        = IDX_W'(s_tdata[5:0]);
                            load_next      = load_rec;
                            load_addr_next = IDX_W'(s_tdata[5:0]);
                            load_en_next   = load_in_range;
                            state_next     = S_CUR;
                        end
                        OP_TICK, OP_YIELD, OP_PDIS, OP_PEN: begin
                            state_next = S_CUR;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_CUR: begin
                scan_next  = '0;
                found_next = 1'b0;
                state_next = S_DONE;
                case (op_reg)
                    OP_TICK: begin
                        if (eff_rec.cnt != 8'd0) begin
                            upd_rec.cnt = eff_rec.cnt - 8'd1;
                        end
                        if (upd_rec.cnt == 8'd0 && eff_rec.pre == 4'd0) begin
                            state_next = S_SCAN;
                        end
                    end
                    OP_YIELD: begin
                        upd_rec.cnt = 8'd0;
                        state_next  = S_SCAN;
                    end
                    OP_LOAD: begin
                        upd_rec     = load_reg;
                        upd_rec.pre = eff_rec.pre;
                    end
                    OP_PDIS: begin
                        if (eff_rec.pre != 4'hF) begin
                            upd_rec.pre = eff_rec.pre + 4'd1;
                        end
                    end
                    OP_PEN: begin
                        if (eff_rec.pre != 4'd0) begin
                            upd_rec.pre = eff_rec.pre - 4'd1;
                        end
                    end
                    default: begin
                    end
                endcase
                wr_en   = 1'b1;
                wr_addr = cur_reg;
                wr_data = upd_rec;
                if (op_reg == OP_LOAD) begin
                    wr_en   = load_en_reg;
                    wr_addr = load_addr_reg;
                end
            end
            S_SCAN, S_RECH: begin
                rd_addr   = scan_reg[IDX_W-1:0];
                live_next = (scan_reg != SCAN_END);
                if (scan_reg != SCAN_END) begin
                    scan_next = scan_reg + (IDX_W + 1)'(1);
                end
                if (state_reg == S_RECH && live_reg && eff_rec.present) begin
                    upd_rec.cnt = rech_cnt;
                    wr_en       = 1'b1;
                    wr_addr     = rd_addr_reg;
                    wr_data     = upd_rec;
                end
                if (pass_end) begin
                    if (state_reg == S_SCAN && found_next && best_cnt_next == 8'd0) begin
                        // Every runnable slot has run out: recharge and pick again.
                        state_next = S_RECH;
                        scan_next  = '0;
                        found_next = 1'b0;
                        live_next  = 1'b0;
                    end else begin
                        cur_next   = found_next ? best_idx_next : '0;
                        rch_next   = (state_reg == S_RECH);
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {rch_reg, (cur_reg != before_reg), 6'(cur_reg)};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cur_reg      <= '0;
            live_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cur_reg      <= cur_next;
            live_reg     <= live_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        before_reg    <= before_next;
        scan_reg      <= scan_next;
        found_reg     <= found_next;
        best_cnt_reg  <= best_cnt_next;
        best_idx_reg  <= best_idx_next;
        rch_reg       <= rch_next;
        m_tdata_reg   <= m_tdata_next;
        load_reg      <= load_next;
        load_addr_reg <= load_addr_next;
        load_en_reg   <= load_en_next;
    end

endmodule

[rtl/cpts_checker.sv]
module cpts_checker
    import cpts_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [S_TUSER_W-1:0] s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // After reset the block is idle with no result pending.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("block not idle after reset");

    // One transaction at a time: the block is busy right after accepting one.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while previous operation in progress");

    // An offered input transaction holds until it is taken.
    a_input_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("input changed while waiting");

    // A stalled result holds.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A result never appears in the cycle right after an input transaction.
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared without processing time");

endmodule

bind counter_priority_task_scheduler cpts_checker u_cpts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
